// ===== rtl/dwgs_pkg.sv =====
// Shared types, constants and helpers for the damped wave stencil step unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package dwgs_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_COLUMNS);
    localparam int COL_W       = 6;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 14;

    // laplacian: four neighbors minus four times the center
    localparam int LAP_W = VALUE_BITS + 3;
    localparam int P1_W  = GAIN_W + 1 + LAP_W;
    localparam int P2_W  = GAIN_W + 1 + VALUE_BITS;
    localparam int ACC_W = P1_W + 1;

    localparam logic [1:0] REG_COLUMNS   = 2'd0;
    localparam logic [1:0] REG_WAVE_GAIN = 2'd1;
    localparam logic [1:0] REG_DAMP_GAIN = 2'd2;
    localparam logic [1:0] REG_TIME_STEP = 2'd3;

    typedef struct packed {
        logic             cap;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             rdb_en;
        logic [IDX_W-1:0] right_addr;
        logic [IDX_W-1:0] left_addr;
        logic             latch;
        logic             lap_en;
        logic             top_use;
        logic             left_use;
        logic             left_prev;
        logic             right_use;
        logic             bottom_self;
        logic             mul_en;
        logic             acc_en;
        logic             mul2_en;
        logic             out_load;
        logic             out_done;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic logic signed [VALUE_BITS-1:0] sat_value(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [VALUE_BITS-1:0] res;
        hi = {{(ACC_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            res = hi[VALUE_BITS-1:0];
        else if (v < lo)
            res = lo[VALUE_BITS-1:0];
        else
            res = v[VALUE_BITS-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dwgs_dp.sv =====
// Datapath of the stencil step unit: row stores, neighbor operands, multipliers,
// rounding and saturation, and the output register. Uses dwgs_pkg; driven by dwgs_ctrl.
`default_nettype none

module dwgs_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dwgs_pkg::dp_cmd_t                   cmd,
    output dwgs_pkg::dp_status_t                     status,
    input  wire logic signed [dwgs_pkg::VALUE_BITS-1:0] in_height,
    input  wire logic signed [dwgs_pkg::VALUE_BITS-1:0] in_velocity,
    input  wire logic [dwgs_pkg::GAIN_W-1:0]         wave_gain,
    input  wire logic [dwgs_pkg::GAIN_W-1:0]         damp_gain,
    input  wire logic [dwgs_pkg::GAIN_W-1:0]         time_step,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [dwgs_pkg::VALUE_BITS-1:0]   out_height,
    output logic signed [dwgs_pkg::VALUE_BITS-1:0]   out_velocity,
    output logic                                     out_done
);

    localparam int VB = dwgs_pkg::VALUE_BITS;
    localparam int AW = dwgs_pkg::ACC_W;
    localparam int LW = dwgs_pkg::LAP_W;

    logic signed [VB-1:0] up_mem [dwgs_pkg::MAX_COLUMNS];
    logic signed [VB-1:0] mh_mem [dwgs_pkg::MAX_COLUMNS];
    logic signed [VB-1:0] mv_mem [dwgs_pkg::MAX_COLUMNS];

    logic signed [VB-1:0] up_q, mh_q, mv_q;
    logic signed [VB-1:0] hin_reg, vin_reg;
    logic signed [VB-1:0] c_reg, top_reg, v_reg, prevc_reg;
    logic signed [LW-1:0] lap_reg;
    logic signed [dwgs_pkg::P1_W-1:0] p1_reg;
    logic signed [dwgs_pkg::P2_W-1:0] p2_reg;
    logic signed [VB-1:0] nv_reg;
    logic signed [dwgs_pkg::P2_W-1:0] p3_reg;
    logic                 out_valid_reg;
    logic signed [VB-1:0] out_h_reg, out_v_reg;
    logic                 out_d_reg;

    logic signed [LW-1:0] top_x, bot_x, left_x, right_x, c_x, lap_sum;
    logic signed [VB-1:0] top_sel, bot_sel, left_sel, right_sel;
    logic signed [AW-1:0] acc_sum, acc_sh, nv_sum, p3_sh, nh_sum;
    logic signed [VB-1:0] nh_val;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            up_mem[cmd.wr_addr] <= c_reg;
            mh_mem[cmd.wr_addr] <= hin_reg;
            mv_mem[cmd.wr_addr] <= vin_reg;
        end
        if (cmd.rd_en)
        begin
            mh_q <= mh_mem[cmd.rd_addr];
            up_q <= up_mem[cmd.rd_addr];
            mv_q <= mv_mem[cmd.rd_addr];
        end
        else if (cmd.rdb_en)
        begin
            mh_q <= mh_mem[cmd.right_addr];
            up_q <= up_mem[cmd.left_addr];
        end
    end

    // neighbor selection with edge clamping
    always_comb
    begin
        top_sel   = cmd.top_use ? top_reg : c_reg;
        bot_sel   = cmd.bottom_self ? c_reg : hin_reg;
        right_sel = cmd.right_use ? mh_q : c_reg;
        if (!cmd.left_use)
            left_sel = c_reg;
        else if (cmd.left_prev)
            left_sel = prevc_reg;
        else
            left_sel = up_q;
        top_x   = {{(LW-VB){top_sel[VB-1]}}, top_sel};
        bot_x   = {{(LW-VB){bot_sel[VB-1]}}, bot_sel};
        left_x  = {{(LW-VB){left_sel[VB-1]}}, left_sel};
        right_x = {{(LW-VB){right_sel[VB-1]}}, right_sel};
        c_x     = {{(LW-VB){c_reg[VB-1]}}, c_reg};
        lap_sum = top_x + bot_x + left_x + right_x - (c_x <<< 2);
    end

    // round to nearest, halves up, then saturate
    always_comb
    begin
        acc_sum = {{(AW-dwgs_pkg::P1_W){p1_reg[dwgs_pkg::P1_W-1]}}, p1_reg}
                - {{(AW-dwgs_pkg::P2_W){p2_reg[dwgs_pkg::P2_W-1]}}, p2_reg}
                + (AW'(1) <<< (dwgs_pkg::GAIN_FRAC - 1));
        acc_sh  = acc_sum >>> dwgs_pkg::GAIN_FRAC;
        nv_sum  = {{(AW-VB){v_reg[VB-1]}}, v_reg} + acc_sh;
        p3_sh   = $signed({{(AW-dwgs_pkg::P2_W){p3_reg[dwgs_pkg::P2_W-1]}}, p3_reg}
                + (AW'(1) <<< (dwgs_pkg::GAIN_FRAC - 1))) >>> dwgs_pkg::GAIN_FRAC;
        nh_sum  = {{(AW-VB){c_reg[VB-1]}}, c_reg} + p3_sh;
        nh_val  = dwgs_pkg::sat_value(nh_sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            hin_reg <= in_height;
            vin_reg <= in_velocity;
        end
        if (cmd.latch)
        begin
            c_reg     <= mh_q;
            top_reg   <= up_q;
            v_reg     <= mv_q;
            prevc_reg <= c_reg;
        end
        if (cmd.lap_en)
            lap_reg <= lap_sum;
        if (cmd.mul_en)
        begin
            p1_reg <= $signed({1'b0, wave_gain}) * lap_reg;
            p2_reg <= $signed({1'b0, damp_gain}) * v_reg;
        end
        if (cmd.acc_en)
            nv_reg <= dwgs_pkg::sat_value(nv_sum);
        if (cmd.mul2_en)
            p3_reg <= $signed({1'b0, time_step}) * nv_reg;
        if (cmd.out_load)
        begin
            out_h_reg <= nh_val;
            out_v_reg <= nv_reg;
            out_d_reg <= cmd.out_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_height   = out_h_reg;
    assign out_velocity = out_v_reg;
    assign out_done     = out_d_reg;

endmodule

`default_nettype wire

// ===== rtl/dwgs_ctrl.sv =====
// Sequencer of the stencil step unit: column position, row count, flush loop,
// and the command word for dwgs_dp. Uses dwgs_pkg.
`default_nettype none

module dwgs_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_last,
    input  wire logic [dwgs_pkg::COL_W-1:0]    columns,
    input  wire dwgs_pkg::dp_status_t          status,
    output dwgs_pkg::dp_cmd_t                  cmd
);

    localparam int IW = dwgs_pkg::IDX_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD_A  = 9'b000000010,
        S_RD_B  = 9'b000000100,
        S_LAP   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_ACC   = 9'b000100000,
        S_MUL2  = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_WRITE = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   col_reg, col_next;
    logic [1:0]      rows_reg, rows_next;
    logic [IW-1:0]   x_reg, x_next;
    logic [IW-1:0]   k_reg, k_next;
    logic            fend_reg, fend_next;
    logic            flush_reg, flush_next;

    logic [dwgs_pkg::COL_W-1:0] cols;
    logic [IW-1:0]   cols_m1, x_in, pos;
    logic            in_fire, row_end;

    always_comb
    begin
        if (columns == '0)
            cols = dwgs_pkg::COL_W'(1);
        else if (columns > dwgs_pkg::COL_W'(dwgs_pkg::MAX_COLUMNS))
            cols = dwgs_pkg::COL_W'(dwgs_pkg::MAX_COLUMNS);
        else
            cols = columns;
        cols_m1 = IW'(cols - dwgs_pkg::COL_W'(1));
        x_in    = (col_reg > cols_m1) ? cols_m1 : col_reg;
        pos     = flush_reg ? k_reg : x_reg;
        row_end = (x_reg == cols_m1);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        rows_next  = rows_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        fend_next  = fend_reg;
        flush_next = flush_reg;

        cmd             = '0;
        cmd.cap         = in_fire;
        cmd.rd_addr     = pos;
        cmd.right_addr  = pos + IW'(1);
        cmd.left_addr   = pos - IW'(1);
        cmd.wr_addr     = x_reg;
        cmd.top_use     = (rows_reg >= 2'd2);
        cmd.left_use    = (pos != '0);
        cmd.left_prev   = flush_reg;
        cmd.right_use   = (pos != cols_m1);
        cmd.bottom_self = flush_reg;
        cmd.out_done    = flush_reg && (k_reg == cols_m1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    x_next     = x_in;
                    fend_next  = in_last;
                    flush_next = 1'b0;
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.latch  = 1'b1;
                cmd.rdb_en = 1'b1;
                // first row has no lower neighbor yet: only shift the stores
                if (!flush_reg && rows_reg == 2'd0)
                    state_next = S_WRITE;
                else
                    state_next = S_LAP;
            end
            S_LAP:
            begin
                cmd.lap_en = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2_en = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (!flush_reg)
                        state_next = S_WRITE;
                    else if (k_reg == cols_m1)
                    begin
                        flush_next = 1'b0;
                        rows_next  = 2'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_RD_A;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                state_next = S_IDLE;
                if (!row_end)
                begin
                    col_next = x_reg + IW'(1);
                    if (fend_reg)
                    begin
                        col_next  = '0;
                        rows_next = 2'd0;
                    end
                end
                else
                begin
                    col_next = '0;
                    if (rows_reg < 2'd2)
                        rows_next = rows_reg + 2'd1;
                    // last cell of the grid: sweep the final row
                    if (fend_reg)
                    begin
                        flush_next = 1'b1;
                        k_next     = '0;
                        state_next = S_RD_A;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            rows_reg  <= 2'd0;
            x_reg     <= '0;
            k_reg     <= '0;
            fend_reg  <= 1'b0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            rows_reg  <= rows_next;
            x_reg     <= x_next;
            k_reg     <= k_next;
            fend_reg  <= fend_next;
            flush_reg <= flush_next;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register still held");

    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg != 2'd3)
        else $error("row count out of range");

    a_fire_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_RD_A) && !flush_reg)
        else $error("accepted item did not start a store read");

    a_write_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (state_reg == S_IDLE) || (state_reg == S_RD_A))
        else $error("bad state after store write");

endmodule

`default_nettype wire

// ===== rtl/damped_wave_grid_stencil_step_unit.sv =====
// Damped wave stencil step unit: top level with the APB register file and the
// stream ports. Instantiates dwgs_ctrl and dwgs_dp; uses dwgs_pkg.
//
// One time step of a damped 2D wave equation over a raster-ordered grid of up to
// 32 columns. An item is accepted only while the unit is idle, so it takes no new
// item until it is through with the last. Each cell makes two reads of the
// single-port row stores; a cell past the first row then runs the multiply, round
// and saturate sequence, and its result may wait on m_tready. A last cell closing
// its row starts a flush sweep over every cell of that row. Results leave one row
// after their cell; m_tlast marks the final cell of a flushed grid. No clearing
// pass follows reset.
`default_nettype none

module damped_wave_grid_stencil_step_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] cell_height, [31:16] cell_velocity
    input  wire logic        s_tlast,   // frame_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] new_height, [31:16] new_velocity
    output logic             m_tlast,   // grid_done
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int VB = dwgs_pkg::VALUE_BITS;
    localparam int GW = dwgs_pkg::GAIN_W;

    logic [dwgs_pkg::COL_W-1:0] columns_reg;
    logic [GW-1:0] wave_gain_reg, damp_gain_reg, time_step_reg;
    logic          cfg_wr;
    logic [1:0]    reg_sel;

    dwgs_pkg::dp_cmd_t    cmd;
    dwgs_pkg::dp_status_t status;
    logic signed [VB-1:0] out_h, out_v;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= dwgs_pkg::COL_W'(32);
            wave_gain_reg <= GW'(4096);
            damp_gain_reg <= GW'(164);
            time_step_reg <= GW'(1638);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                dwgs_pkg::REG_COLUMNS:   columns_reg   <= pwdata[dwgs_pkg::COL_W-1:0];
                dwgs_pkg::REG_WAVE_GAIN: wave_gain_reg <= pwdata[GW-1:0];
                dwgs_pkg::REG_DAMP_GAIN: damp_gain_reg <= pwdata[GW-1:0];
                dwgs_pkg::REG_TIME_STEP: time_step_reg <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            dwgs_pkg::REG_COLUMNS:   prdata = {{(32-dwgs_pkg::COL_W){1'b0}}, columns_reg};
            dwgs_pkg::REG_WAVE_GAIN: prdata = {{(32-GW){1'b0}}, wave_gain_reg};
            dwgs_pkg::REG_DAMP_GAIN: prdata = {{(32-GW){1'b0}}, damp_gain_reg};
            dwgs_pkg::REG_TIME_STEP: prdata = {{(32-GW){1'b0}}, time_step_reg};
            default:                 prdata = '0;
        endcase
    end

    dwgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_last  (s_tlast),
        .columns  (columns_reg),
        .status   (status),
        .cmd      (cmd)
    );

    dwgs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_height    (s_tdata[VB-1:0]),
        .in_velocity  (s_tdata[2*VB-1:VB]),
        .wave_gain    (wave_gain_reg),
        .damp_gain    (damp_gain_reg),
        .time_step    (time_step_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_height   (out_h),
        .out_velocity (out_v),
        .out_done     (m_tlast)
    );

    assign m_tdata = {out_v, out_h};

endmodule

`default_nettype wire
